>>> rtl/spom_pkg.sv
// shared types and constants of the spiral-order matrix reader
package spom_pkg;

    localparam int ELEM_W    = 16;
    localparam int IDX_W     = 4;
    localparam int VALUE_W   = 16;
    localparam int CNT_W     = 5;
    localparam int CFG_IDX_W = 1;

    // command field codes
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_EMIT = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_COL_COUNT = 1'b1;

    typedef struct packed {
        logic               command;
        logic [VALUE_W-1:0] value;
    } t_in_item;

    typedef struct packed {
        logic [ELEM_W-1:0] element;
        logic [IDX_W-1:0]  row_index;
        logic [IDX_W-1:0]  col_index;
        logic              last;
    } t_out_item;

    // controller to datapath commands
    typedef struct packed {
        logic load;    // store one element at the load position
        logic emit;    // latch spiral position, step the walk
        logic read;    // registered memory read of the latched address
        logic cfg_wr;  // configuration register write
    } t_dp_cmd;

endpackage

>>> rtl/spiral_order_matrix_reader.sv
// top level of the spiral-order matrix reader
// A load (command 0) leaves busy low: the next command may start in the
// following cycle. An emit (command 1) raises busy, which is high for one
// cycle while the matrix memory is read through its registered read port;
// the address is registered, then the read data, and the result strobe
// o_result_valid is then high for exactly one cycle with the element, its row and
// column and the last flag. The receiver cannot stall: each result beat is on
// the ports for that one cycle only. A new command may start in the cycle of
// the strobe. Configuration writes (row_count at index 0, col_count at index
// 1) are always ready and restart both the row-major load position and the
// spiral walk, the stored elements are kept. Write configuration only while
// no emit is in flight. No clearing pass runs after reset: elements must be
// loaded before they are emitted.
module spiral_order_matrix_reader #(
    parameter int MAX_ROWS  = 16,
    parameter int MAX_COLS  = 16,
    parameter int DATA_BITS = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // command channel
    input  logic                            start,
    output logic                            busy,
    input  spom_pkg::t_in_item              i_in,
    // result channel
    output logic                            o_result_valid,
    output spom_pkg::t_out_item             o_result,
    // configuration channel
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [spom_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [spom_pkg::CNT_W-1:0]      i_cfg_data
);

    spom_pkg::t_dp_cmd cmd;

    // registers accept a write in any cycle
    assign o_cfg_ready = 1'b1;

    spom_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .i_command      (i_in.command),
        .i_cfg_valid    (i_cfg_valid),
        .busy           (busy),
        .o_result_valid (o_result_valid),
        .o_cmd          (cmd)
    );

    // memory, load pointer, bounds and walk position
    spom_datapath #(
        .MAX_ROWS  (MAX_ROWS),
        .MAX_COLS  (MAX_COLS),
        .DATA_BITS (DATA_BITS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_value     (i_in.value),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_result    (o_result)
    );

endmodule

>>> rtl/spom_ctrl.sv
// controller state machine of the spiral-order matrix reader
module spom_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    input  logic                i_command,
    input  logic                i_cfg_valid,
    output logic                busy,
    output logic                o_result_valid,
    output spom_pkg::t_dp_cmd   o_cmd
);

    typedef enum logic {
        S_IDLE,
        S_READ
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_busy;
    logic   n_busy;
    logic   r_valid;
    logic   n_valid;
    logic   accept;

    assign accept = start && !r_busy;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept && (i_command == spom_pkg::CMD_EMIT)) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        n_busy  = (n_state == S_READ);
        n_valid = (r_state == S_READ);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_busy  <= n_busy;
            r_valid <= n_valid;
        end
    end

    always_comb begin
        o_cmd.load   = accept && (i_command == spom_pkg::CMD_LOAD);
        o_cmd.emit   = accept && (i_command == spom_pkg::CMD_EMIT);
        o_cmd.read   = (r_state == S_READ);
        o_cmd.cfg_wr = i_cfg_valid;
    end

    assign busy           = r_busy;
    assign o_result_valid = r_valid;

endmodule

>>> rtl/spom_datapath.sv
// datapath: matrix memory, load pointer, spiral walk registers
module spom_datapath #(
    parameter int MAX_ROWS  = 16,
    parameter int MAX_COLS  = 16,
    parameter int DATA_BITS = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  spom_pkg::t_dp_cmd                  i_cmd,
    input  logic [spom_pkg::VALUE_W-1:0]       i_value,
    input  logic [spom_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [spom_pkg::CNT_W-1:0]         i_cfg_data,
    output spom_pkg::t_out_item                o_result
);

    localparam int DEPTH  = MAX_ROWS * MAX_COLS;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW     = spom_pkg::CNT_W;
    localparam int POS_W  = 2 * CW;
    localparam int CNT_MAX = (1 << CW) - 1;
    localparam logic [CW-1:0] ROW_LIM = CW'((MAX_ROWS > CNT_MAX) ? CNT_MAX : MAX_ROWS);
    localparam logic [CW-1:0] COL_LIM = CW'((MAX_COLS > CNT_MAX) ? CNT_MAX : MAX_COLS);
    localparam logic [CW-1:0] CNT_RESET = CW'(16);

    typedef logic signed [CW:0] t_bnd;

    typedef enum logic [1:0] {
        DIR_RIGHT,
        DIR_DOWN,
        DIR_LEFT,
        DIR_UP
    } t_dir;

    typedef struct packed {
        t_bnd top;
        t_bnd bottom;
        t_bnd left;
        t_bnd right;
        t_bnd row;
        t_bnd col;
        t_dir dir;
        logic wrap;
    } t_walk;

    function automatic logic [CW-1:0] f_used(logic [CW-1:0] cnt, logic [CW-1:0] lim);
        logic [CW-1:0] res;
        if (cnt == '0) begin
            res = CW'(1);
        end else if (cnt > lim) begin
            res = lim;
        end else begin
            res = cnt;
        end
        return res;
    endfunction

    // one spiral step, turning past empty segments, at most four turns
    function automatic t_walk f_advance(t_walk w);
        t_walk n;
        logic  done;
        n      = w;
        n.wrap = 1'b0;
        done   = 1'b0;
        case (w.dir)
            DIR_RIGHT: begin
                if (w.col < w.right) begin
                    n.col = w.col + t_bnd'(1);
                    done  = 1'b1;
                end
            end
            DIR_DOWN: begin
                if (w.row < w.bottom) begin
                    n.row = w.row + t_bnd'(1);
                    done  = 1'b1;
                end
            end
            DIR_LEFT: begin
                if (w.col > w.left) begin
                    n.col = w.col - t_bnd'(1);
                    done  = 1'b1;
                end
            end
            default: begin
                if (w.row > w.top) begin
                    n.row = w.row - t_bnd'(1);
                    done  = 1'b1;
                end
            end
        endcase
        for (int t = 0; t < 4; t++) begin
            if (!done) begin
                case (n.dir)
                    DIR_RIGHT: begin
                        n.top = n.top + t_bnd'(1);
                        n.dir = DIR_DOWN;
                        n.row = n.top;
                        n.col = n.right;
                    end
                    DIR_DOWN: begin
                        n.right = n.right - t_bnd'(1);
                        n.dir   = DIR_LEFT;
                        n.row   = n.bottom;
                        n.col   = n.right;
                    end
                    DIR_LEFT: begin
                        n.bottom = n.bottom - t_bnd'(1);
                        n.dir    = DIR_UP;
                        n.row    = n.bottom;
                        n.col    = n.left;
                    end
                    default: begin
                        n.left = n.left + t_bnd'(1);
                        n.dir  = DIR_RIGHT;
                        n.row  = n.top;
                        n.col  = n.left;
                    end
                endcase
                if ((n.top <= n.bottom) && (n.left <= n.right)) begin
                    done = 1'b1;
                end
            end
        end
        n.wrap = !done;
        return n;
    endfunction

    logic [DATA_BITS-1:0] r_mem [DEPTH];

    logic [CW-1:0]        r_row_cnt, n_row_cnt;
    logic [CW-1:0]        r_col_cnt, n_col_cnt;
    logic [POS_W-1:0]     r_load_pos, n_load_pos;
    logic [POS_W-1:0]     r_emit_cnt, n_emit_cnt;
    t_bnd                 r_top, n_top;
    t_bnd                 r_bottom, n_bottom;
    t_bnd                 r_left, n_left;
    t_bnd                 r_right, n_right;
    logic [CW-1:0]        r_walk_row, n_walk_row;
    logic [CW-1:0]        r_walk_col, n_walk_col;
    t_dir                 r_dir, n_dir;
    logic [ADDR_W-1:0]    r_addr;
    logic [DATA_BITS-1:0] r_rd_data;
    logic [spom_pkg::IDX_W-1:0] r_res_row;
    logic [spom_pkg::IDX_W-1:0] r_res_col;
    logic                 r_res_last;

    logic [CW-1:0]        rows, cols, rows_n, cols_n;
    logic [POS_W-1:0]     total;
    logic [POS_W-1:0]     walk_addr;
    logic [POS_W-1:0]     pos_inc;
    logic [POS_W-1:0]     wr_pos;
    logic                 is_last;
    t_walk                cur_walk;
    t_walk                nxt_walk;

    always_comb begin
        n_row_cnt = r_row_cnt;
        n_col_cnt = r_col_cnt;
        if (i_cmd.cfg_wr) begin
            case (i_cfg_index)
                spom_pkg::CFG_ROW_COUNT: n_row_cnt = i_cfg_data;
                spom_pkg::CFG_COL_COUNT: n_col_cnt = i_cfg_data;
                default:                 n_row_cnt = r_row_cnt;
            endcase
        end
    end

    assign rows      = f_used(r_row_cnt, ROW_LIM);
    assign cols      = f_used(r_col_cnt, COL_LIM);
    assign rows_n    = f_used(n_row_cnt, ROW_LIM);
    assign cols_n    = f_used(n_col_cnt, COL_LIM);
    assign total     = POS_W'(rows) * POS_W'(cols);
    assign walk_addr = POS_W'(r_walk_row) * POS_W'(cols) + POS_W'(r_walk_col);
    assign wr_pos    = (r_load_pos >= total) ? '0 : r_load_pos;
    assign pos_inc   = wr_pos + POS_W'(1);
    assign is_last   = (r_emit_cnt + POS_W'(1)) >= total;

    always_comb begin
        cur_walk.top    = r_top;
        cur_walk.bottom = r_bottom;
        cur_walk.left   = r_left;
        cur_walk.right  = r_right;
        cur_walk.row    = $signed({1'b0, r_walk_row});
        cur_walk.col    = $signed({1'b0, r_walk_col});
        cur_walk.dir    = r_dir;
        cur_walk.wrap   = 1'b0;
        nxt_walk        = f_advance(cur_walk);
    end

    always_comb begin
        n_load_pos = r_load_pos;
        n_emit_cnt = r_emit_cnt;
        n_top      = r_top;
        n_bottom   = r_bottom;
        n_left     = r_left;
        n_right    = r_right;
        n_walk_row = r_walk_row;
        n_walk_col = r_walk_col;
        n_dir      = r_dir;
        if (i_cmd.load) begin
            n_load_pos = (pos_inc >= total) ? '0 : pos_inc;
        end else if (i_cmd.emit && !is_last && !nxt_walk.wrap) begin
            n_emit_cnt = r_emit_cnt + POS_W'(1);
            n_top      = nxt_walk.top;
            n_bottom   = nxt_walk.bottom;
            n_left     = nxt_walk.left;
            n_right    = nxt_walk.right;
            n_walk_row = CW'(nxt_walk.row);
            n_walk_col = CW'(nxt_walk.col);
            n_dir      = nxt_walk.dir;
        end
        // restart: on any register write, after the final element
        if (i_cmd.cfg_wr || (i_cmd.emit && (is_last || nxt_walk.wrap))) begin
            n_emit_cnt = '0;
            n_top      = '0;
            n_bottom   = $signed({1'b0, rows_n}) - t_bnd'(1);
            n_left     = '0;
            n_right    = $signed({1'b0, cols_n}) - t_bnd'(1);
            n_walk_row = '0;
            n_walk_col = '0;
            n_dir      = DIR_RIGHT;
        end
        if (i_cmd.cfg_wr) begin
            n_load_pos = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_cnt  <= CNT_RESET;
            r_col_cnt  <= CNT_RESET;
            r_load_pos <= '0;
            r_emit_cnt <= '0;
            r_top      <= '0;
            r_bottom   <= $signed({1'b0, f_used(CNT_RESET, ROW_LIM)}) - t_bnd'(1);
            r_left     <= '0;
            r_right    <= $signed({1'b0, f_used(CNT_RESET, COL_LIM)}) - t_bnd'(1);
            r_walk_row <= '0;
            r_walk_col <= '0;
            r_dir      <= DIR_RIGHT;
        end else begin
            r_row_cnt  <= n_row_cnt;
            r_col_cnt  <= n_col_cnt;
            r_load_pos <= n_load_pos;
            r_emit_cnt <= n_emit_cnt;
            r_top      <= n_top;
            r_bottom   <= n_bottom;
            r_left     <= n_left;
            r_right    <= n_right;
            r_walk_row <= n_walk_row;
            r_walk_col <= n_walk_col;
            r_dir      <= n_dir;
        end
    end

    // result side registers, no reset
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_addr     <= ADDR_W'(walk_addr);
            r_res_row  <= r_walk_row[spom_pkg::IDX_W-1:0];
            r_res_col  <= r_walk_col[spom_pkg::IDX_W-1:0];
            r_res_last <= is_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mem[ADDR_W'(wr_pos)] <= DATA_BITS'(i_value);
        end
        if (i_cmd.read) begin
            r_rd_data <= r_mem[r_addr];
        end
    end

    always_comb begin
        o_result.element   = spom_pkg::ELEM_W'(r_rd_data);
        o_result.row_index = r_res_row;
        o_result.col_index = r_res_col;
        o_result.last      = r_res_last;
    end

endmodule

>>> rtl/spom_checker.sv
// port-level checks of the spiral-order matrix reader and their binding
module spom_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            start,
    input logic                            busy,
    input spom_pkg::t_in_item              i_in,
    input logic                            o_result_valid
);

    logic emit_acc;
    logic load_acc;

    assign emit_acc = start && !busy && (i_in.command == spom_pkg::CMD_EMIT);
    assign load_acc = start && !busy && (i_in.command == spom_pkg::CMD_LOAD);

    // an emit holds off the next command for the memory read
    a_emit_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit_acc |=> busy)
        else $error("emit not followed by busy");

    // every emit gives one result beat after the memory read
    a_emit_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit_acc |-> ##2 o_result_valid)
        else $error("emit without result beat");

    // a load gives no result beat
    a_load_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_acc |-> ##2 !o_result_valid)
        else $error("result beat after a load");

    // a result beat lasts one cycle and the block is free during it
    a_beat_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> (!busy ##1 !o_result_valid))
        else $error("result beat longer than one cycle or busy during it");

endmodule

bind spiral_order_matrix_reader spom_checker u_spom_checker (.*);

>>> sim/testbench.sv
// self-checking testbench of the spiral-order matrix reader
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_ROWS    = 16;
    localparam int MAX_COLS    = 16;
    localparam int DATA_BITS   = 16;
    localparam int STORE_DEPTH = MAX_ROWS * MAX_COLS;
    localparam int ITEM_TARGET = 1450;

    // heading of the spiral walk
    typedef enum logic [1:0] {GO_RIGHT, GO_DOWN, GO_LEFT, GO_UP} t_heading;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    // command channel
    logic                 start = 1'b0;
    logic                 busy;
    spom_pkg::t_in_item   i_in = '0;

    // result channel
    logic                 o_result_valid;
    spom_pkg::t_out_item  o_result;

    // configuration channel
    logic                           i_cfg_valid = 1'b0;
    logic                           o_cfg_ready;
    logic [spom_pkg::CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [spom_pkg::CNT_W-1:0]     i_cfg_data = '0;

    spiral_order_matrix_reader #(
        .MAX_ROWS  (MAX_ROWS),
        .MAX_COLS  (MAX_COLS),
        .DATA_BITS (DATA_BITS)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_in           (i_in),
        .o_result_valid (o_result_valid),
        .o_result       (o_result),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // shadow of the block: count registers, load position, spiral walk
    // ------------------------------------------------------------------
    logic [spom_pkg::CNT_W-1:0]  row_reg = 5'd16;
    logic [spom_pkg::CNT_W-1:0]  col_reg = 5'd16;
    logic [spom_pkg::ELEM_W-1:0] matrix_copy [STORE_DEPTH];
    int                          load_pos = 0;
    int                          top_b, bot_b, left_b, right_b;
    int                          walk_r, walk_c;
    t_heading                    heading;
    int                          emitted;

    // results owed by the block, oldest first
    spom_pkg::t_out_item  emit_forecast [$];
    // commands waiting for the driver
    spom_pkg::t_in_item   cmd_backlog [$];

    int fail_count = 0;
    bit steady_feed = 1'b0;   // no driver gaps while set

    // stimulus-side view: where the next load lands and which cells hold data
    int fill_pos = 0;
    bit filled [STORE_DEPTH];
    int queued = 0;

    logic [spom_pkg::CNT_W-1:0] count_extremes [5] = '{5'd0, 5'd1, 5'd16, 5'd17, 5'd31};

    // zero counts act as one, anything past the array size acts as the size
    function automatic int clamp_count(logic [spom_pkg::CNT_W-1:0] v, int ceiling);
        if (v == 0) return 1;
        if (v > ceiling) return ceiling;
        return int'(v);
    endfunction

    function automatic int cells_in_use();
        return clamp_count(row_reg, MAX_ROWS) * clamp_count(col_reg, MAX_COLS);
    endfunction

    function automatic void restart_spiral();
        top_b   = 0;
        bot_b   = clamp_count(row_reg, MAX_ROWS) - 1;
        left_b  = 0;
        right_b = clamp_count(col_reg, MAX_COLS) - 1;
        walk_r  = 0;
        walk_c  = 0;
        heading = GO_RIGHT;
        emitted = 0;
    endfunction

    // one step clockwise; at the end of a side pull that bound in and turn,
    // skipping sides that have become empty
    function automatic void walk_forward();
        int turn;
        case (heading)
            GO_RIGHT: if (walk_c < right_b) begin
                walk_c++;
                return;
            end
            GO_DOWN: if (walk_r < bot_b) begin
                walk_r++;
                return;
            end
            GO_LEFT: if (walk_c > left_b) begin
                walk_c--;
                return;
            end
            default: if (walk_r > top_b) begin
                walk_r--;
                return;
            end
        endcase
        for (turn = 0; turn < 4; turn++) begin
            case (heading)
                GO_RIGHT: begin
                    top_b++;
                    heading = GO_DOWN;
                    walk_r = top_b;
                    walk_c = right_b;
                end
                GO_DOWN: begin
                    right_b--;
                    heading = GO_LEFT;
                    walk_r = bot_b;
                    walk_c = right_b;
                end
                GO_LEFT: begin
                    bot_b--;
                    heading = GO_UP;
                    walk_r = bot_b;
                    walk_c = left_b;
                end
                default: begin
                    left_b++;
                    heading = GO_RIGHT;
                    walk_r = top_b;
                    walk_c = left_b;
                end
            endcase
            if (top_b <= bot_b && left_b <= right_b) return;
        end
        restart_spiral();
    endfunction

    // apply one accepted command to the shadow, queue the result an emit owes
    function automatic void follow_command(spom_pkg::t_in_item cmd);
        int                  rows, cols, total, r, c;
        spom_pkg::t_out_item res;
        rows  = clamp_count(row_reg, MAX_ROWS);
        cols  = clamp_count(col_reg, MAX_COLS);
        total = rows * cols;
        if (cmd.command == spom_pkg::CMD_LOAD) begin
            if (load_pos >= total) load_pos = 0;
            matrix_copy[load_pos % STORE_DEPTH] = cmd.value[DATA_BITS-1:0];
            load_pos++;
            if (load_pos >= total) load_pos = 0;
            return;
        end
        r = (walk_r < 0) ? 0 : walk_r;
        c = (walk_c < 0) ? 0 : walk_c;
        if (r >= rows) r = rows - 1;
        if (c >= cols) c = cols - 1;
        res.element   = matrix_copy[(r * cols + c) % STORE_DEPTH];
        res.row_index = r[spom_pkg::IDX_W-1:0];
        res.col_index = c[spom_pkg::IDX_W-1:0];
        res.last      = (emitted + 1 >= total);
        emit_forecast = {emit_forecast, res};
        if (res.last) begin
            restart_spiral();
        end else begin
            emitted++;
            walk_forward();
        end
    endfunction

    function automatic void note_failure(string msg);
        fail_count++;
        if (fail_count <= 10) $display("tb: %s", msg);
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    function automatic logic [spom_pkg::VALUE_W-1:0] pick_value();
        case ($urandom_range(7))
            0: return '0;
            1: return '1;
            default: return spom_pkg::VALUE_W'($urandom);
        endcase
    endfunction

    function automatic void queue_load(logic [spom_pkg::VALUE_W-1:0] v);
        spom_pkg::t_in_item it;
        it.command = spom_pkg::CMD_LOAD;
        it.value   = v;
        cmd_backlog = {cmd_backlog, it};
        filled[fill_pos] = 1'b1;
        fill_pos = (fill_pos + 1) % cells_in_use();
        queued++;
    endfunction

    // value bits of an emit are don't-care, so they get random content
    function automatic void queue_emit();
        spom_pkg::t_in_item it;
        it.command = spom_pkg::CMD_EMIT;
        it.value   = spom_pkg::VALUE_W'($urandom);
        cmd_backlog = {cmd_backlog, it};
        queued++;
    endfunction

    // an emit may only land on cells that were loaded at some point
    function automatic bit grid_loaded();
        int i;
        for (i = 0; i < cells_in_use(); i++)
            if (!filled[i]) return 1'b0;
        return 1'b1;
    endfunction

    // one register write beat; shadow and fill position follow the restart
    task automatic write_count(input logic [spom_pkg::CFG_IDX_W-1:0] idx,
                               input logic [spom_pkg::CNT_W-1:0] data);
        @(posedge i_clk);
        while ($urandom_range(99) < 22) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == spom_pkg::CFG_ROW_COUNT) begin
            row_reg = data;
        end else begin
            col_reg = data;
        end
        load_pos = 0;
        restart_spiral();
        fill_pos = 0;
    endtask

    // wait for the block to go quiet, then write the counts;
    // new commands are queued from the following falling edge
    task automatic set_geometry(input logic [spom_pkg::CNT_W-1:0] rows,
                                input logic [spom_pkg::CNT_W-1:0] cols,
                                input bit cols_only);
        do @(posedge i_clk);
        while (cmd_backlog.size() != 0 || start || emit_forecast.size() != 0);
        // leave a little margin after the last result beat
        repeat (4) @(posedge i_clk);
        if (cols_only) begin
            write_count(spom_pkg::CFG_COL_COUNT, cols);
        end else if ($urandom_range(1)) begin
            write_count(spom_pkg::CFG_ROW_COUNT, rows);
            write_count(spom_pkg::CFG_COL_COUNT, cols);
        end else begin
            write_count(spom_pkg::CFG_COL_COUNT, cols);
            write_count(spom_pkg::CFG_ROW_COUNT, rows);
        end
        @(negedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // driver: one command beat per start/!busy edge, random gaps
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) follow_command(i_in);
            // hold the beat while the block is busy
            if (!start || !busy) begin
                if (cmd_backlog.size() != 0 && (steady_feed || $urandom_range(99) >= 22)) begin
                    start <= 1'b1;
                    i_in  <= cmd_backlog.pop_front();
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // monitor: each result strobe is checked against the oldest forecast
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        spom_pkg::t_out_item want;
        if (i_rst_n && o_result_valid) begin
            if (emit_forecast.size() == 0) begin
                note_failure($sformatf("unexpected result beat: elem %h row %0d col %0d last %0b",
                    o_result.element, o_result.row_index, o_result.col_index,
                    o_result.last));
            end else begin
                want = emit_forecast.pop_front();
                if (o_result.element !== want.element ||
                    o_result.row_index !== want.row_index ||
                    o_result.col_index !== want.col_index ||
                    o_result.last !== want.last) begin
                    note_failure({
                        $sformatf("mismatch: want elem %h row %0d col %0d last %0b",
                            want.element, want.row_index, want.col_index, want.last),
                        $sformatf(", got elem %h row %0d col %0d last %0b",
                            o_result.element, o_result.row_index, o_result.col_index,
                            o_result.last)});
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    initial begin
        int                         phase;
        int                         total, laps, emits, waited;
        logic [spom_pkg::CNT_W-1:0] rows_sel, cols_sel;

        restart_spiral();
        foreach (matrix_copy[i]) matrix_copy[i] = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // single cell: every emit is both the first and the last of its spiral
        set_geometry(5'd1, 5'd1, 1'b0);
        queue_load(16'hFFFF);
        queue_emit();
        queue_load(16'h0000);
        queue_emit();
        queue_emit();

        // 2x3: top row, right column, bottom row back, then wrap to the start
        set_geometry(5'd2, 5'd3, 1'b0);
        queue_load(16'h0001);
        queue_load(16'h0002);
        queue_load(16'h8000);
        queue_load(16'h4000);
        queue_load(16'hAAAA);
        queue_load(16'h5555);
        repeat (7) queue_emit();

        // zero counts behave as one
        set_geometry(5'd0, 5'd0, 1'b0);
        queue_emit();
        queue_emit();

        // single column: the walk only goes down, no left or up leg
        set_geometry(5'd3, 5'd1, 1'b0);
        queue_load(16'h1234);
        repeat (4) queue_emit();

        // random phases, mostly small grids
        phase = 0;
        while (queued < ITEM_TARGET) begin
            phase++;
            steady_feed = (phase >= 10 && phase < 16);
            case ($urandom_range(9))
                0: begin
                    rows_sel = spom_pkg::CNT_W'($urandom_range(31));
                    cols_sel = spom_pkg::CNT_W'($urandom_range(31));
                end
                1: begin
                    rows_sel = count_extremes[$urandom_range(4)];
                    cols_sel = count_extremes[$urandom_range(4)];
                end
                default: begin
                    rows_sel = spom_pkg::CNT_W'($urandom_range(1, 6));
                    cols_sel = spom_pkg::CNT_W'($urandom_range(1, 6));
                end
            endcase
            set_geometry(rows_sel, cols_sel, $urandom_range(4) == 0);
            total = cells_in_use();

            if ($urandom_range(4) == 0) begin
                // loose mix, often leaves the fill and the walk half done
                repeat ($urandom_range(1, 24)) begin
                    if (grid_loaded() && $urandom_range(1)) begin
                        queue_emit();
                    end else begin
                        queue_load(pick_value());
                    end
                end
            end else begin
                // full fill then whole spirals, sometimes cut short by the next write
                if (!grid_loaded() || $urandom_range(1)) begin
                    repeat (total) begin
                        if (queued >= ITEM_TARGET) break;
                        queue_load(pick_value());
                    end
                end
                laps  = (total > 64) ? 1 : $urandom_range(1, 3);
                emits = laps * total;
                if ($urandom_range(3) == 0) emits += $urandom_range(0, total - 1);
                repeat (emits) begin
                    if (queued >= ITEM_TARGET) break;
                    if ($urandom_range(6) == 0) queue_load(pick_value());
                    queue_emit();
                end
            end
        end
        steady_feed = 1'b0;

        // drain: every command taken, then the owed results
        do @(posedge i_clk); while (cmd_backlog.size() != 0 || start);
        waited = 0;
        while (emit_forecast.size() != 0 && waited < 64) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (8) @(posedge i_clk);
        if (emit_forecast.size() != 0)
            note_failure($sformatf("%0d result beats never arrived", emit_forecast.size()));

        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // hard stop, far beyond the slowest legal run
    initial begin
        #1000000;
        $display("tb: failure");
        $finish;
    end

endmodule
